FILE: src/tft_pkg.sv
package tft_pkg;

  typedef struct packed {
    logic [7:0]  status_byte;
    logic [15:0] primary_temp;
    logic [15:0] exhaust_temp;
    logic [30:0] vin_q16;
    logic [15:0] iin_milliamps;
    logic [15:0] pin_tenths;
    logic [15:0] line_frequency;
    logic [15:0] vbus_adc;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       frame_end;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_SEND
  } frame_state_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_MUL,
    C_NORM
  } calc_state_t;

  typedef struct packed {
    logic       start;
    logic [3:0] cmd;
  } calc_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] data;
  } calc_rsp_t;

  localparam logic [3:0] CMD_PTEMP = 4'd1;
  localparam logic [3:0] CMD_FW_LO = 4'd2;
  localparam logic [3:0] CMD_VIN   = 4'd3;
  localparam logic [3:0] CMD_VBUS  = 4'd4;
  localparam logic [3:0] CMD_FW_HI = 4'd5;
  localparam logic [3:0] CMD_ETEMP = 4'd6;
  localparam logic [3:0] CMD_ZERO  = 4'd7;
  localparam logic [3:0] CMD_IIN   = 4'd8;
  localparam logic [3:0] CMD_PIN   = 4'd9;
  localparam logic [3:0] CMD_FREQ  = 4'd10;
  localparam logic [3:0] CMD_FIRST = CMD_PTEMP;
  localparam logic [3:0] CMD_LAST  = CMD_FREQ;

  localparam logic [1:0] CFG_HEADER  = 2'd0;
  localparam logic [1:0] CFG_FW_REV  = 2'd1;
  localparam logic [1:0] CFG_VBUS_FS = 2'd2;

  localparam logic [7:0]  HEADER_RST  = 8'hAA;
  localparam logic [31:0] FW_REV_RST  = 32'd0;
  localparam logic [15:0] VBUS_FS_RST = 16'd512;

  localparam logic [9:0]  DIV_MILLI   = 10'd1000;
  localparam logic [9:0]  DIV_TEN     = 10'd10;
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam logic [31:0] RECIP_MILLI = 32'h1062_4DD3;
  localparam logic [31:0] MANT_MAX    = 32'd1023;
  localparam logic signed [4:0] EXP_START = -5'sd16;
  localparam logic signed [4:0] EXP_MAX   = 5'sd15;

  localparam logic [2:0] IDX_HEADER = 3'd0;
  localparam logic [2:0] IDX_STATUS = 3'd1;
  localparam logic [2:0] IDX_CMD    = 3'd2;
  localparam logic [2:0] IDX_LO     = 3'd3;
  localparam logic [2:0] IDX_HI     = 3'd4;
  localparam logic [2:0] IDX_CSUM   = 3'd5;

endpackage

FILE: src/tft_calc.sv
module tft_calc
  import tft_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  calc_req_t   req,
  input  in_item_t    item,
  input  logic [31:0] rev_word,
  input  logic [15:0] vbus_full_scale,
  output calc_rsp_t   rsp
);

  calc_state_t       st_r, st_nxt;
  logic [31:0]       acc_r, acc_nxt;
  logic [15:0]       op_a_r, op_a_nxt;
  logic [31:0]       op_b_r, op_b_nxt;
  logic [3:0]        cmd_r, cmd_nxt;
  logic signed [4:0] exp_r, exp_nxt;
  logic [15:0]       data_r, data_nxt;
  logic              done_r, done_nxt;

  logic [47:0] prod;
  logic [32:0] rounded;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= C_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    acc_r  <= acc_nxt;
    op_a_r <= op_a_nxt;
    op_b_r <= op_b_nxt;
    cmd_r  <= cmd_nxt;
    exp_r  <= exp_nxt;
    data_r <= data_nxt;
  end

  always_comb begin
    prod    = {32'h0, op_a_r} * {16'h0, op_b_r};
    rounded = {1'b0, acc_r} + 33'd1;
  end

  always_comb begin
    st_nxt   = st_r;
    acc_nxt  = acc_r;
    op_a_nxt = op_a_r;
    op_b_nxt = op_b_r;
    cmd_nxt  = cmd_r;
    exp_nxt  = exp_r;
    data_nxt = data_r;
    done_nxt = 1'b0;
    case (st_r)
      C_IDLE: begin
        if (req.start) begin
          exp_nxt = EXP_START;
          cmd_nxt = req.cmd;
          case (req.cmd)
            CMD_PTEMP: begin
              data_nxt = item.primary_temp;
              done_nxt = 1'b1;
            end
            CMD_FW_LO: begin
              data_nxt = rev_word[15:0];
              done_nxt = 1'b1;
            end
            CMD_VIN: begin
              acc_nxt = {1'b0, item.vin_q16};
              st_nxt  = C_NORM;
            end
            CMD_VBUS: begin
              op_a_nxt = item.vbus_adc;
              op_b_nxt = {16'h0, vbus_full_scale};
              st_nxt   = C_MUL;
            end
            CMD_FW_HI: begin
              data_nxt = rev_word[31:16];
              done_nxt = 1'b1;
            end
            CMD_ETEMP: begin
              data_nxt = item.exhaust_temp;
              done_nxt = 1'b1;
            end
            CMD_IIN: begin
              op_a_nxt = item.iin_milliamps;
              op_b_nxt = RECIP_MILLI;
              st_nxt   = C_MUL;
            end
            CMD_PIN: begin
              op_a_nxt = item.pin_tenths;
              op_b_nxt = RECIP_TEN;
              st_nxt   = C_MUL;
            end
            CMD_FREQ: begin
              op_a_nxt = item.line_frequency;
              op_b_nxt = RECIP_TEN;
              st_nxt   = C_MUL;
            end
            default: begin
              data_nxt = 16'h0;
              done_nxt = 1'b1;
            end
          endcase
        end
      end
      C_MUL: begin
        case (cmd_r)
          CMD_IIN: begin
            acc_nxt = {9'h0, prod[44:22]};
            st_nxt  = C_NORM;
          end
          CMD_PIN: begin
            acc_nxt = {3'h0, prod[47:19]};
            st_nxt  = C_NORM;
          end
          CMD_FREQ: begin
            data_nxt = {3'h0, prod[47:35]};
            done_nxt = 1'b1;
            st_nxt   = C_IDLE;
          end
          CMD_VBUS: begin
            data_nxt = prod[27:12];
            done_nxt = 1'b1;
            st_nxt   = C_IDLE;
          end
          default: begin
            data_nxt = 16'h0;
            done_nxt = 1'b1;
            st_nxt   = C_IDLE;
          end
        endcase
      end
      C_NORM: begin
        if (acc_r > MANT_MAX && exp_r < EXP_MAX) begin
          acc_nxt = rounded[32:1];
          exp_nxt = exp_r + 5'sd1;
        end else begin
          data_nxt = {exp_r, acc_r[10:0]};
          done_nxt = 1'b1;
          st_nxt   = C_IDLE;
        end
      end
      default: st_nxt = C_IDLE;
    endcase
  end

  assign rsp = '{done: done_r, data: data_r};

  a_done_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(st_r) != C_IDLE || $past(req.start)))
    else $error("result without work");

  a_norm_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == C_NORM && $past(st_r) == C_NORM) |-> exp_r != EXP_START)
    else $error("exponent did not advance");

  a_start_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (req.start && st_r != C_IDLE) |-> 1'b0)
    else $error("start while busy");

endmodule

FILE: src/telemetry_frame_transmitter_top.sv
// On the path from accept to first byte, raw payloads go straight to the frame, bus
// voltage and frequency use the one shared multiply, current and power then add one
// Linear11 halving per cycle, and vin uses the halvings alone. Six bytes then leave
// one per cycle while the output is not stalled. A new request is taken once the
// checksum byte sits in the output register.
// Synchronous active-low reset: registers to defaults, counter to 1, no output.
module telemetry_frame_transmitter_top
  import tft_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  frame_state_t state_r, state_nxt;
  logic [3:0]   cnt_r, cnt_nxt;
  logic [3:0]   cmd_r, cmd_nxt;
  logic [7:0]   status_r, status_nxt;
  logic [15:0]  data_r, data_nxt;
  logic [2:0]   idx_r, idx_nxt;
  logic         out_valid_r, out_valid_nxt;
  out_item_t    out_r, out_nxt;
  logic [7:0]   header_r;
  logic [31:0]  fw_rev_r;
  logic [15:0]  vbus_fs_r;

  logic      in_xfer;
  logic      load;
  logic [7:0] sum5;
  logic [7:0] byte_sel;
  calc_req_t req;
  calc_rsp_t rsp;

  tft_calc u_calc (
    .clk             (clk),
    .rst_n           (rst_n),
    .req             (req),
    .item            (in_data),
    .rev_word        (fw_rev_r),
    .vbus_full_scale (vbus_fs_r),
    .rsp             (rsp)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign req       = '{start: in_xfer, cmd: cnt_r};
  assign load      = (state_r == S_SEND) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r  <= HEADER_RST;
      fw_rev_r  <= FW_REV_RST;
      vbus_fs_r <= VBUS_FS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HEADER:  header_r  <= cfg_data[7:0];
        CFG_FW_REV:  fw_rev_r  <= cfg_data;
        CFG_VBUS_FS: vbus_fs_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= CMD_FIRST;
      idx_r       <= IDX_HEADER;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r    <= cmd_nxt;
    status_r <= status_nxt;
    data_r   <= data_nxt;
    out_r    <= out_nxt;
  end

  always_comb begin
    sum5 = header_r + status_r + {4'h0, cmd_r} + data_r[7:0] + data_r[15:8];
    case (idx_r)
      IDX_HEADER: byte_sel = header_r;
      IDX_STATUS: byte_sel = status_r;
      IDX_CMD:    byte_sel = {4'h0, cmd_r};
      IDX_LO:     byte_sel = data_r[7:0];
      IDX_HI:     byte_sel = data_r[15:8];
      IDX_CSUM:   byte_sel = 8'h00 - sum5;
      default:    byte_sel = 8'h00;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd_nxt       = cmd_r;
    status_nxt    = status_r;
    data_nxt      = data_r;
    idx_nxt       = idx_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_nxt    = cnt_r;
          status_nxt = in_data.status_byte;
          cnt_nxt    = (cnt_r >= CMD_FIRST && cnt_r < CMD_LAST) ? cnt_r + 4'd1 : CMD_FIRST;
          state_nxt  = S_CALC;
        end
      end
      S_CALC: begin
        if (rsp.done) begin
          data_nxt  = rsp.data;
          idx_nxt   = IDX_HEADER;
          state_nxt = S_SEND;
        end
      end
      S_SEND: begin
        if (load) begin
          out_nxt.tx_byte   = byte_sel;
          out_nxt.frame_end = (idx_r == IDX_CSUM);
          out_valid_nxt     = 1'b1;
          idx_nxt           = idx_r + 3'd1;
          if (idx_r == IDX_CSUM) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r >= CMD_FIRST && cnt_r <= CMD_LAST)
    else $error("command counter out of range");

  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> state_r == S_CALC)
    else $error("calc result outside calc phase");

  a_frame_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (load && idx_r == IDX_CSUM) |=> (state_r == S_IDLE && out_valid_r && out_r.frame_end))
    else $error("frame did not close on checksum");

  a_end_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (load && idx_r != IDX_CSUM) |=> !out_r.frame_end)
    else $error("frame end on inner byte");

endmodule

FILE: tb/tft_frame_checker.sv
module tft_frame_checker
  import tft_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  logic [7:0]  header_reg;
  logic [31:0] fw_rev_reg;
  logic [15:0] vbus_fs_reg;
  logic [3:0]  cmd_count;
  out_item_t   frame_bytes_q[$];

  task automatic flag_mismatch(input string msg);
    $display("%0t frame check: %s", $time, msg);
    fail_count++;
  endtask

  function automatic logic [15:0] linear11_word(input logic [63:0] q16);
    int          ex;
    logic [63:0] mant;
    ex   = EXP_START;
    mant = q16;
    while (mant > MANT_MAX && ex < EXP_MAX) begin
      ex++;
      mant = (mant + 64'd1) >> 1;
    end
    return {ex[4:0], mant[10:0]};
  endfunction

  function automatic logic [15:0] frame_payload(input in_item_t it, input logic [3:0] cmd);
    logic [31:0] scaled;
    case (cmd)
      CMD_PTEMP: return it.primary_temp;
      CMD_FW_LO: return fw_rev_reg[15:0];
      CMD_VIN:   return linear11_word(64'(it.vin_q16));
      CMD_VBUS: begin
        scaled = 32'(it.vbus_adc) * 32'(vbus_fs_reg);
        return scaled[27:12];
      end
      CMD_FW_HI: return fw_rev_reg[31:16];
      CMD_ETEMP: return it.exhaust_temp;
      CMD_ZERO:  return 16'd0;
      CMD_IIN:   return linear11_word((64'(it.iin_milliamps) << 16) / 64'(DIV_MILLI));
      CMD_PIN:   return linear11_word((64'(it.pin_tenths) << 16) / 64'(DIV_TEN));
      CMD_FREQ:  return it.line_frequency / 16'(DIV_TEN);
      default:   return 16'd0;
    endcase
  endfunction

  task automatic queue_frame(input in_item_t it);
    logic [15:0] data;
    logic [7:0]  bytes [6];
    logic [7:0]  sum;
    data = frame_payload(it, cmd_count);
    bytes[IDX_HEADER] = header_reg;
    bytes[IDX_STATUS] = it.status_byte;
    bytes[IDX_CMD]    = {4'd0, cmd_count};
    bytes[IDX_LO]     = data[7:0];
    bytes[IDX_HI]     = data[15:8];
    sum = bytes[IDX_HEADER] + bytes[IDX_STATUS] + bytes[IDX_CMD] + bytes[IDX_LO]
        + bytes[IDX_HI];
    bytes[IDX_CSUM] = 8'd0 - sum;
    for (int i = 0; i < 6; i++) begin
      frame_bytes_q.push_back('{tx_byte: bytes[i], frame_end: (i == IDX_CSUM)});
    end
    if (cmd_count >= CMD_FIRST && cmd_count < CMD_LAST) cmd_count = cmd_count + 4'd1;
    else cmd_count = CMD_FIRST;
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      header_reg  = HEADER_RST;
      fw_rev_reg  = FW_REV_RST;
      vbus_fs_reg = VBUS_FS_RST;
      cmd_count   = CMD_FIRST;
      fail_count  = 0;
      frame_bytes_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_HEADER:  header_reg  = cfg_data[7:0];
          CFG_FW_REV:  fw_rev_reg  = cfg_data;
          CFG_VBUS_FS: vbus_fs_reg = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) queue_frame(in_data);
      if (out_valid && !out_stall) begin
        if (frame_bytes_q.size() == 0) begin
          flag_mismatch($sformatf("byte %02h with no frame pending", out_data.tx_byte));
        end else begin
          want = frame_bytes_q.pop_front();
          if (out_data.tx_byte !== want.tx_byte)
            flag_mismatch($sformatf("tx_byte got %02h want %02h",
                                    out_data.tx_byte, want.tx_byte));
          if (out_data.frame_end !== want.frame_end)
            flag_mismatch($sformatf("frame_end got %0b want %0b",
                                    out_data.frame_end, want.frame_end));
        end
      end
    end
    pending = frame_bytes_q.size();
  end

endmodule

FILE: tb/tb_telemetry_frame_transmitter_top.sv
module tb_telemetry_frame_transmitter_top;
  import tft_pkg::*;

  localparam int RAND_PER_PHASE = 85;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_LIMIT    = 50000;
  localparam int TAIL_CYCLES    = 80;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;

  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_reqs     = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  telemetry_frame_transmitter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tft_frame_checker u_frame_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // hold off the receiver for a long stretch on request, else stall at random
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_request(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_regs(input logic [7:0] hdr, input logic [31:0] fw,
                           input logic [15:0] fs);
    write_reg(CFG_HEADER, {24'd0, hdr});
    write_reg(CFG_FW_REV, fw);
    write_reg(CFG_VBUS_FS, {16'd0, fs});
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_frames();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic in_item_t rand_telemetry();
    in_item_t it;
    it.status_byte    = 8'($urandom);
    it.primary_temp   = 16'($urandom);
    it.exhaust_temp   = 16'($urandom);
    it.vin_q16        = 31'($urandom >> $urandom_range(31));
    it.iin_milliamps  = 16'($urandom >> $urandom_range(16));
    it.pin_tenths     = 16'($urandom >> $urandom_range(16));
    it.line_frequency = 16'($urandom);
    it.vbus_adc       = 16'($urandom >> $urandom_range(8));
    return it;
  endfunction

  task automatic send_random(input bit with_hold);
    for (int n = 0; n < RAND_PER_PHASE; n++) begin
      if (with_hold && n == 20) hold_reqs++;
      send_request(rand_telemetry());
    end
  endtask

  initial begin : stimulus
    in_item_t it;
    logic [7:0] part;
    int guard;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 17;
    recv_idle_pct = 62;

    repeat (10) send_request('1);
    repeat (10) send_request('0);

    // checksum of a zero byte sum on a primary temperature frame
    it = '0;
    it.primary_temp = 16'h80FE;
    part = HEADER_RST + {4'd0, CMD_PTEMP} + it.primary_temp[7:0] + it.primary_temp[15:8];
    it.status_byte = 8'd0 - part;
    send_request(it);
    send_request(rand_telemetry());
    it = rand_telemetry();
    it.vin_q16 = 31'(MANT_MAX) + 31'd1;
    send_request(it);
    it = rand_telemetry();
    it.vbus_adc = 16'h1000;
    send_request(it);
    send_request(rand_telemetry());

    drain_frames();
    load_regs(8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_random(1'b0);

    drain_frames();
    send_idle_pct = 62;
    recv_idle_pct = 17;
    load_regs(8'h00, $urandom, 16'h0000);
    send_random(1'b0);

    drain_frames();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_regs(8'($urandom), $urandom, 16'($urandom));
    send_random(1'b1);

    in_valid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (pending != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("telemetry_frame_transmitter_top regression: pass");
    end else begin
      $display("telemetry_frame_transmitter_top regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("telemetry_frame_transmitter_top regression: fail");
    $finish;
  end

endmodule
